/* src/slet_pkg.sv */
// ----------------------------------------------------------------------------
// slet_pkg - shared types and constants of the literal escape transcoder
// Phase codes, status codes and the item carried from the front to the back.
// ----------------------------------------------------------------------------
package slet_pkg;

	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_SAW3   = 8'b0000_0010,
		PH_SAW1   = 8'b0000_0100,
		PH_WIDTH  = 8'b0000_1000,
		PH_ORDER  = 8'b0001_0000,
		PH_BODY   = 8'b0010_0000,
		PH_ESC    = 8'b0100_0000,
		PH_DIGITS = 8'b1000_0000
	} phase_t;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_UTF8  = 3'd1;
	localparam logic [2:0] ST_ESC   = 3'd2;
	localparam logic [2:0] ST_DIGIT = 3'd3;
	localparam logic [2:0] ST_RANGE = 3'd4;

	localparam logic [1:0] US_8  = 2'd0;
	localparam logic [1:0] US_16 = 2'd1;
	localparam logic [1:0] US_32 = 2'd2;

	localparam logic [20:0] CP_MAX = 21'h10FFFF;
	localparam logic [20:0] CP_OVF = 21'h110000;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// command from front to back: either a code point or a status-only item
	typedef struct packed {
		logic        is_cp;
		logic [20:0] cp;
		logic [1:0]  unit;
		logic        little;
		logic        done;
		logic [2:0]  status;
	} cmd_t;

endpackage

/* src/slet_front.sv */
// ----------------------------------------------------------------------------
// slet_front - prefix parse, utf-8 and escape decode
// Consumes one item per cycle if the queue has room, at most one command each.
// ----------------------------------------------------------------------------
module slet_front import slet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       native_little,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       token_start,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	phase_t      phase_q;
	logic [1:0]  unit_q;
	logic [1:0]  order_q;
	logic [7:0]  delim_q;
	logic [20:0] acc_q;
	logic [3:0]  digits_q;
	logic [1:0]  u8left_q;
	logic        hex_q;

	phase_t      phase_d;
	logic [1:0]  unit_d;
	logic [1:0]  order_d;
	logic [7:0]  delim_d;
	logic [20:0] acc_d;
	logic [3:0]  digits_d;
	logic [1:0]  u8left_d;
	logic        hex_d;
	logic        push;
	cmd_t        c;

	logic        little;
	logic [3:0]  dig;
	logic        dig_ok;
	logic [24:0] acc_next;
	logic [7:0]  delim_eff;

	assign in_ready = cmd_ready;
	assign little = (order_q == 2'd1) || (order_q != 2'd2 && native_little);

	// digit value of the current byte
	always_comb begin
		dig = 4'd0;
		dig_ok = 1'b0;
		if (in_byte >= "0" && in_byte <= "7") begin
			dig = in_byte[3:0]; dig_ok = 1'b1;
		end else if (hex_q && (in_byte == "8" || in_byte == "9")) begin
			dig = in_byte[3:0]; dig_ok = 1'b1;
		end else if (hex_q && ((in_byte >= "A" && in_byte <= "F") ||
			(in_byte >= "a" && in_byte <= "f"))) begin
			dig = in_byte[3:0] + 4'd9; dig_ok = 1'b1;
		end
		acc_next = hex_q ? {acc_q, dig} : {1'b0, acc_q, dig[2:0]};
	end

	// next state and command
	always_comb begin
		logic bodyrun;
		logic ok;
		phase_d = phase_q; unit_d = unit_q; order_d = order_q; delim_d = delim_q;
		acc_d = acc_q; digits_d = digits_q; u8left_d = u8left_q; hex_d = hex_q;
		push = 1'b0;
		bodyrun = 1'b0;
		ok = 1'b0;
		delim_eff = delim_q;
		c = '0;
		c.unit = unit_q;
		c.little = little;
		if (token_start) begin
			unit_d = US_8; order_d = 2'd0; delim_d = 8'd0; acc_d = '0;
			digits_d = '0; u8left_d = '0; hex_d = 1'b0;
			if (in_byte == "3") phase_d = PH_SAW3;
			else if (in_byte == "1") phase_d = PH_SAW1;
			else if (in_byte == "8") phase_d = PH_WIDTH;
			else if (in_byte == "L" || in_byte == "l") begin
				order_d = 2'd1; phase_d = PH_ORDER;
			end else if (in_byte == "B" || in_byte == "b") begin
				order_d = 2'd2; phase_d = PH_ORDER;
			end else begin
				delim_d = in_byte; phase_d = PH_BODY;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_SAW3, PH_SAW1: begin
					if (phase_q == PH_SAW3 && in_byte == "2") begin
						unit_d = US_32; phase_d = PH_WIDTH;
					end else if (phase_q == PH_SAW1 && in_byte == "6") begin
						unit_d = US_16; phase_d = PH_WIDTH;
					end else begin
						delim_eff = (phase_q == PH_SAW3) ? 8'h33 : 8'h31;
						delim_d = delim_eff;
						phase_d = PH_BODY;
						bodyrun = 1'b1;
					end
				end
				PH_WIDTH: begin
					if (in_byte == "L" || in_byte == "l") begin
						order_d = 2'd1; phase_d = PH_ORDER;
					end else if (in_byte == "B" || in_byte == "b") begin
						order_d = 2'd2; phase_d = PH_ORDER;
					end else begin
						delim_d = in_byte; phase_d = PH_BODY;
					end
				end
				PH_ORDER: begin
					delim_d = in_byte; phase_d = PH_BODY;
				end
				PH_BODY: bodyrun = 1'b1;
				PH_ESC: begin
					phase_d = PH_BODY;
					push = 1'b1;
					c.is_cp = 1'b1;
					case (in_byte)
						"a": c.cp = 21'h07;
						"b": c.cp = 21'h08;
						"e": c.cp = 21'h1B;
						"f": c.cp = 21'h0C;
						"n": c.cp = 21'h0A;
						"t": c.cp = 21'h09;
						"r": c.cp = 21'h0D;
						"v": c.cp = 21'h0B;
						"\\", "'", "\"": c.cp = {13'd0, in_byte};
						"z": c.cp = 21'h0;
						"0", "1", "2", "3", "4", "5", "6", "7": begin
							push = 1'b0;
							acc_d = {18'd0, in_byte[2:0]};
							digits_d = (unit_q == US_8) ? 4'd2 :
								(unit_q == US_16) ? 4'd5 : 4'd10;
							hex_d = 1'b0;
							phase_d = PH_DIGITS;
						end
						"x", "u", "U": begin
							push = 1'b0;
							acc_d = '0;
							digits_d = (in_byte == "x") ? 4'd2 :
								(in_byte == "u") ? 4'd4 : 4'd8;
							hex_d = 1'b1;
							phase_d = PH_DIGITS;
						end
						default: begin
							c.is_cp = 1'b0;
							c.status = ST_ESC;
							c.done = (in_byte == delim_q);
							phase_d = c.done ? PH_IDLE : PH_BODY;
						end
					endcase
				end
				PH_DIGITS: begin
					if (!dig_ok) begin
						digits_d = '0;
						push = 1'b1;
						c.status = ST_DIGIT;
						c.done = (in_byte == delim_q);
						phase_d = c.done ? PH_IDLE : PH_BODY;
					end else begin
						if (acc_q > CP_MAX || acc_next > {4'd0, CP_MAX}) acc_d = CP_OVF;
						else acc_d = acc_next[20:0];
						digits_d = digits_q - 4'd1;
						if (digits_q == 4'd1) begin
							phase_d = PH_BODY;
							push = 1'b1;
							c.is_cp = 1'b1;
							c.cp = acc_d;
						end
					end
				end
				default: ;
			endcase
		end
		// body byte: utf-8 continuation or lead, delimiter, escape or ascii
		if (bodyrun) begin
			if (u8left_q != 2'd0) begin
				ok = (in_byte[7:6] == 2'b10);
				if (u8left_q == 2'd3) begin
					if (acc_q == 21'd0 && in_byte < 8'h90) ok = 1'b0;
					if (acc_q == 21'd4 && in_byte > 8'h8F) ok = 1'b0;
				end else if (u8left_q == 2'd2 && acc_q < 21'd16) begin
					if (acc_q == 21'd0 && in_byte < 8'hA0) ok = 1'b0;
					if (acc_q == 21'hD && in_byte > 8'h9F) ok = 1'b0;
				end
				if (!ok) begin
					u8left_d = '0;
					push = 1'b1;
					c.status = ST_UTF8;
					c.done = (in_byte == delim_eff);
					phase_d = c.done ? PH_IDLE : PH_BODY;
				end else begin
					acc_d = {acc_q[14:0], in_byte[5:0]};
					u8left_d = u8left_q - 2'd1;
					if (u8left_q == 2'd1) begin
						push = 1'b1; c.is_cp = 1'b1; c.cp = acc_d;
					end
				end
			end else if (in_byte == delim_eff) begin
				push = 1'b1; c.done = 1'b1; phase_d = PH_IDLE;
			end else if (in_byte == "\\") begin
				phase_d = PH_ESC;
			end else if (!in_byte[7]) begin
				push = 1'b1; c.is_cp = 1'b1; c.cp = {13'd0, in_byte};
			end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
				acc_d = {16'd0, in_byte[4:0]}; u8left_d = 2'd1;
			end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
				acc_d = {17'd0, in_byte[3:0]}; u8left_d = 2'd2;
			end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
				acc_d = {18'd0, in_byte[2:0]}; u8left_d = 2'd3;
			end else begin
				push = 1'b1; c.status = ST_UTF8;
			end
		end
	end

	assign cmd_valid = in_valid && push;
	assign cmd = c;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; unit_q <= US_8; order_q <= '0; delim_q <= '0;
			acc_q <= '0; digits_q <= '0; u8left_q <= '0; hex_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			phase_q <= phase_d; unit_q <= unit_d; order_q <= order_d;
			delim_q <= delim_d; acc_q <= acc_d; digits_q <= digits_d;
			u8left_q <= u8left_d; hex_q <= hex_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && !token_start) |-> !push)
		else $error("result pushed outside a literal");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_BODY) |-> (u8left_q == 2'd0))
		else $error("utf-8 sequence left open outside body");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIGITS) |-> (digits_q != 4'd0))
		else $error("digit phase with no digits left");

endmodule

/* src/slet_queue.sv */
// ----------------------------------------------------------------------------
// slet_queue - short command queue between front and back
// Register array with head and tail pointers and a fill count.
// ----------------------------------------------------------------------------
module slet_queue import slet_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);

	cmd_t         mem_q [QDEPTH];
	logic [QAW-1:0] head_q, tail_q;
	logic [QAW:0]   count_q;
	logic           wr, rd;

	assign wr_ready = (count_q != QAW'(0) + (QAW+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[head_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[tail_q] <= wr_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; tail_q <= '0; count_q <= '0;
		end else begin
			if (wr) tail_q <= tail_q + 1'b1;
			if (rd) head_q <= head_q + 1'b1;
			count_q <= count_q + (QAW+1)'(wr) - (QAW+1)'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a write");

endmodule

/* src/slet_back.sv */
// ----------------------------------------------------------------------------
// slet_back - code point encoder
// Turns one command into one to four output items, one per cycle while ready.
// ----------------------------------------------------------------------------
module slet_back import slet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       char_last,
	output logic       literal_done,
	output logic [2:0] status
);

	logic [1:0] idx_q;
	logic [1:0] nbytes;
	logic [7:0] b [4];
	logic       bad;
	logic [19:0] cs;
	logic [15:0] hi, lo;
	logic [31:0] w32;
	logic        last;

	// encode the whole code point; idx selects the byte
	always_comb begin
		bad = cmd.is_cp && (cmd.cp > CP_MAX || (cmd.cp >= 21'hD800 && cmd.cp <= 21'hDFFF));
		cs = 20'(cmd.cp - 21'h10000);
		hi = 16'hD800 | {6'd0, cs[19:10]};
		lo = 16'hDC00 | {6'd0, cs[9:0]};
		w32 = {11'd0, cmd.cp};
		for (int k = 0; k < 4; k++) b[k] = 8'd0;
		nbytes = 2'd0;
		if (!cmd.is_cp || bad) begin
			nbytes = 2'd0;
		end else if (cmd.unit == US_8) begin
			if (cmd.cp < 21'h80) begin
				b[0] = cmd.cp[7:0];
			end else if (cmd.cp < 21'h800) begin
				nbytes = 2'd1;
				b[0] = {3'b110, cmd.cp[10:6]}; b[1] = {2'b10, cmd.cp[5:0]};
			end else if (cmd.cp < 21'h10000) begin
				nbytes = 2'd2;
				b[0] = {4'b1110, cmd.cp[15:12]}; b[1] = {2'b10, cmd.cp[11:6]};
				b[2] = {2'b10, cmd.cp[5:0]};
			end else begin
				nbytes = 2'd3;
				b[0] = {5'b11110, cmd.cp[20:18]}; b[1] = {2'b10, cmd.cp[17:12]};
				b[2] = {2'b10, cmd.cp[11:6]}; b[3] = {2'b10, cmd.cp[5:0]};
			end
		end else if (cmd.unit == US_16) begin
			if (cmd.cp < 21'h10000) begin
				nbytes = 2'd1;
				b[0] = cmd.little ? cmd.cp[7:0] : cmd.cp[15:8];
				b[1] = cmd.little ? cmd.cp[15:8] : cmd.cp[7:0];
			end else begin
				nbytes = 2'd3;
				b[0] = cmd.little ? hi[7:0] : hi[15:8];
				b[1] = cmd.little ? hi[15:8] : hi[7:0];
				b[2] = cmd.little ? lo[7:0] : lo[15:8];
				b[3] = cmd.little ? lo[15:8] : lo[7:0];
			end
		end else begin
			nbytes = 2'd3;
			for (int k = 0; k < 4; k++)
				b[k] = cmd.little ? w32[8*k +: 8] : w32[24-8*k +: 8];
		end
		last = (idx_q == nbytes);
	end

	// output fields
	always_comb begin
		out_valid = cmd_valid;
		has_byte = cmd.is_cp && !bad;
		out_byte = has_byte ? b[idx_q] : 8'd0;
		char_last = has_byte && last;
		literal_done = cmd.done;
		status = bad ? ST_RANGE : cmd.status;
		cmd_ready = out_ready && last;
	end

	// byte index within the current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (out_valid && out_ready) idx_q <= last ? 2'd0 : idx_q + 2'd1;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> cmd_valid)
		else $error("byte index advanced without a command");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> last)
		else $error("status item spans several bytes");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (idx_q == $past(idx_q)))
		else $error("byte index moved while stalled");

endmodule

/* src/string_literal_escape_transcoder.sv */
// ----------------------------------------------------------------------------
// string_literal_escape_transcoder - literal token to utf-8/16/32 bytes
// Front parser, command queue and byte encoder.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the command queue has room; each
// byte yields at most one command, and the encoder sends one output item per
// cycle while the receiver is ready; a code point gives one item per encoded
// byte (one to four, four for utf-32), a status item one. The encoder's single
// output port sets the sustained rate; the four-entry queue absorbs bursts.
module string_literal_escape_transcoder import slet_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tuser,   // token_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic [4:0]  m_tuser,   // has_byte, char_last, status
	output logic        m_tlast    // literal_done
);

	logic native_little_q;
	logic fq_valid, fq_ready, qb_valid, qb_ready;
	cmd_t fq_cmd, qb_cmd;
	logic [7:0] ob;
	logic hb, cl, ld;
	logic [2:0] st;

	// native byte order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) native_little_q <= 1'b1;
		else if (cfg_we) native_little_q <= cfg_wdata;
	end

	slet_front u_front (
		.clk, .arst_n, .native_little(native_little_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
		.token_start(s_tuser), .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
	);

	slet_queue u_queue (
		.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
	);

	slet_back u_back (
		.clk, .arst_n, .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_byte(ob), .has_byte(hb),
		.char_last(cl), .literal_done(ld), .status(st)
	);

	assign m_tdata = ob;
	assign m_tuser = {st, cl, hb};
	assign m_tlast = ld;

endmodule

/* tb/slet_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slet_checker - byte stream predictor and scoreboard for the transcoder
// Watches both channels and the register write, predicts the encoded bytes
// of every accepted input item and compares each output item in order.
// ----------------------------------------------------------------------------
module slet_checker import slet_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tuser,   // token_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // out_byte
	input  logic [4:0]  m_tuser,   // has_byte, char_last, status
	input  logic        m_tlast,   // literal_done
	output int          errors,
	output int          pending
);

	typedef enum logic [1:0] {ORD_NATIVE, ORD_LITTLE, ORD_BIG} order_t;

	// expected output word: {status, literal_done, char_last, has_byte, out_byte}
	logic [13:0] enc_expect[$];

	logic        native_le;
	phase_t      tok_phase;
	logic [1:0]  unit_sz;
	order_t      ord;
	logic [7:0]  delim;
	logic [31:0] acc;
	logic [3:0]  digs;
	logic [1:0]  u8left;
	logic        hexmode;
	logic [13:0] got;

	assign pending = enc_expect.size();
	assign got = {m_tuser[4:2], m_tlast, m_tuser[1], m_tuser[0], m_tdata};

	task automatic report(input string what, input logic [13:0] seen, input logic [13:0] want);
		$display("mismatch: %s got %h expected %h at %0t", what, seen, want, $realtime);
		errors++;
	endtask

	task automatic put(input logic [7:0] b, input bit has, input bit last, input bit done,
			input logic [2:0] st);
		enc_expect.push_back({st, done, last, has, b});
	endtask

	task automatic fail_at(input logic [7:0] b, input logic [2:0] st);
		bit done;
		done = (b == delim);
		put(8'h00, 0, 0, done, st);
		tok_phase = done ? PH_IDLE : PH_BODY;
	endtask

	task automatic put16(input logic [15:0] u, input bit little, input bit last);
		put(little ? u[7:0] : u[15:8], 1, 0, 0, ST_OK);
		put(little ? u[15:8] : u[7:0], 1, last, 0, ST_OK);
	endtask

	// encode one code point in the current unit size and byte order
	task automatic encode_cp(input logic [31:0] cp);
		bit little;
		logic [31:0] c;
		little = (ord == ORD_LITTLE) || (ord != ORD_BIG && native_le);
		if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
			put(8'h00, 0, 0, 0, ST_RANGE);
		end else if (unit_sz == US_8) begin
			if (cp < 32'h80) begin
				put(cp[7:0], 1, 1, 0, ST_OK);
			end else if (cp < 32'h800) begin
				put(8'hC0 | cp[10:6], 1, 0, 0, ST_OK);
				put(8'h80 | cp[5:0], 1, 1, 0, ST_OK);
			end else if (cp < 32'h10000) begin
				put(8'hE0 | cp[15:12], 1, 0, 0, ST_OK);
				put(8'h80 | cp[11:6], 1, 0, 0, ST_OK);
				put(8'h80 | cp[5:0], 1, 1, 0, ST_OK);
			end else begin
				put(8'hF0 | cp[20:18], 1, 0, 0, ST_OK);
				put(8'h80 | cp[17:12], 1, 0, 0, ST_OK);
				put(8'h80 | cp[11:6], 1, 0, 0, ST_OK);
				put(8'h80 | cp[5:0], 1, 1, 0, ST_OK);
			end
		end else if (unit_sz == US_16) begin
			if (cp < 32'h10000) begin
				put16(cp[15:0], little, 1);
			end else begin
				c = cp - 32'h10000;
				put16(16'hD800 | c[19:10], little, 0);
				put16(16'hDC00 | c[9:0], little, 1);
			end
		end else begin
			for (int k = 0; k < 4; k++)
				put(little ? cp[8*k +: 8] : cp[24-8*k +: 8], 1, k == 3, 0, ST_OK);
		end
	endtask

	task automatic take_width(input logic [7:0] b);
		if (b == "L" || b == "l") begin
			ord = ORD_LITTLE;
			tok_phase = PH_ORDER;
		end else if (b == "B" || b == "b") begin
			ord = ORD_BIG;
			tok_phase = PH_ORDER;
		end else begin
			delim = b;
			tok_phase = PH_BODY;
		end
	endtask

	task automatic take_body(input logic [7:0] b);
		bit ok;
		if (u8left != 0) begin
			ok = (b[7:6] == 2'b10);
			if (u8left == 3) begin
				if (acc == 0 && b < 8'h90) ok = 0;
				if (acc == 4 && b > 8'h8F) ok = 0;
			end else if (u8left == 2 && acc < 16) begin
				if (acc == 0 && b < 8'hA0) ok = 0;
				if (acc == 13 && b > 8'h9F) ok = 0;
			end
			if (!ok) begin
				u8left = 0;
				fail_at(b, ST_UTF8);
				return;
			end
			acc = (acc << 6) | {26'd0, b[5:0]};
			u8left--;
			if (u8left == 0) encode_cp(acc);
			return;
		end
		if (b == delim) begin
			put(8'h00, 0, 0, 1, ST_OK);
			tok_phase = PH_IDLE;
		end else if (b == "\\") begin
			tok_phase = PH_ESC;
		end else if (b < 8'h80) begin
			encode_cp({24'd0, b});
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			acc = {27'd0, b[4:0]};
			u8left = 1;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			acc = {28'd0, b[3:0]};
			u8left = 2;
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			acc = {29'd0, b[2:0]};
			u8left = 3;
		end else begin
			put(8'h00, 0, 0, 0, ST_UTF8);
		end
	endtask

	task automatic take_escape(input logic [7:0] b);
		logic [31:0] cp;
		tok_phase = PH_BODY;
		case (b)
			"a": cp = 32'h07;
			"b": cp = 32'h08;
			"e": cp = 32'h1B;
			"f": cp = 32'h0C;
			"n": cp = 32'h0A;
			"t": cp = 32'h09;
			"r": cp = 32'h0D;
			"v": cp = 32'h0B;
			"\\", "'", "\"": cp = {24'd0, b};
			"z": cp = 32'h0;
			"0", "1", "2", "3", "4", "5", "6", "7": begin
				acc = {29'd0, b[2:0]};
				digs = (unit_sz == US_8) ? 4'd2 : (unit_sz == US_16) ? 4'd5 : 4'd10;
				hexmode = 0;
				tok_phase = PH_DIGITS;
				return;
			end
			"x", "u", "U": begin
				acc = 0;
				digs = (b == "x") ? 4'd2 : (b == "u") ? 4'd4 : 4'd8;
				hexmode = 1;
				tok_phase = PH_DIGITS;
				return;
			end
			default: begin
				fail_at(b, ST_ESC);
				return;
			end
		endcase
		encode_cp(cp);
	endtask

	task automatic take_digit(input logic [7:0] b);
		logic [31:0] d;
		bit ok;
		ok = 1;
		d = 0;
		if (b >= "0" && b <= "7") d = 32'(b - "0");
		else if (hexmode && (b == "8" || b == "9")) d = 32'(b - "0");
		else if (hexmode && b >= "A" && b <= "F") d = 32'(b - "A") + 32'd10;
		else if (hexmode && b >= "a" && b <= "f") d = 32'(b - "a") + 32'd10;
		else ok = 0;
		if (!ok) begin
			digs = 0;
			fail_at(b, ST_DIGIT);
			return;
		end
		// once past the top code point the value sticks just above it
		if (acc > 32'h10FFFF) begin
			acc = 32'h110000;
		end else begin
			acc = hexmode ? ((acc << 4) | d) : (acc * 32'd8 + d);
			if (acc > 32'h10FFFF) acc = 32'h110000;
		end
		digs = digs - 4'd1;
		if (digs == 0) begin
			tok_phase = PH_BODY;
			encode_cp(acc);
		end
	endtask

	task automatic predict(input logic [7:0] b, input bit start);
		if (start) begin
			unit_sz = US_8;
			ord = ORD_NATIVE;
			delim = 0;
			acc = 0;
			digs = 0;
			u8left = 0;
			hexmode = 0;
			if (b == "3") tok_phase = PH_SAW3;
			else if (b == "1") tok_phase = PH_SAW1;
			else if (b == "8") tok_phase = PH_WIDTH;
			else take_width(b);
			return;
		end
		case (tok_phase)
			PH_SAW3, PH_SAW1: begin
				if ((tok_phase == PH_SAW3 && b == "2") || (tok_phase == PH_SAW1 && b == "6")) begin
					unit_sz = (tok_phase == PH_SAW3) ? US_32 : US_16;
					tok_phase = PH_WIDTH;
				end else begin
					delim = (tok_phase == PH_SAW3) ? "3" : "1";
					tok_phase = PH_BODY;
					take_body(b);
				end
			end
			PH_WIDTH: take_width(b);
			PH_ORDER: begin
				delim = b;
				tok_phase = PH_BODY;
			end
			PH_BODY:   take_body(b);
			PH_ESC:    take_escape(b);
			PH_DIGITS: take_digit(b);
			default: ;
		endcase
	endtask

	// watch both channels and the register
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			enc_expect.delete();
			native_le = 1;
			tok_phase = PH_IDLE;
			unit_sz = US_8;
			ord = ORD_NATIVE;
			delim = 0;
			acc = 0;
			digs = 0;
			u8left = 0;
			hexmode = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (enc_expect.size() == 0)
					report("unexpected item", got, 14'd0);
				else begin
					logic [13:0] want;
					want = enc_expect.pop_front();
					if (got[7:0] != want[7:0])
						report("out_byte", got, want);
					else if (got[8] != want[8])
						report("has_byte", got, want);
					else if (got[9] != want[9])
						report("char_last", got, want);
					else if (got[10] != want[10])
						report("literal_done", got, want);
					else if (got[13:11] != want[13:11])
						report("status", got, want);
				end
			end
			if (cfg_we)
				native_le = cfg_wdata;
			if (s_tvalid && s_tready)
				predict(s_tdata, s_tuser);
		end
	end

endmodule

/* tb/tb_string_literal_escape_transcoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_string_literal_escape_transcoder - stimulus top for the transcoder
// Sends directed and random literal tokens in bursts under several byte-order
// settings, stalls the output side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_string_literal_escape_transcoder;
	import slet_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_wdata = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = 0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [7:0]  m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;
	int          errors;
	int          pending;
	int          sent_items = 0;
	int          burst_left = 0;

	always #1 clk = ~clk;

	string_literal_escape_transcoder dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	slet_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .errors(errors), .pending(pending)
	);

	// receiver stall pattern, with one long hold-off
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0) mode = $urandom_range(0, 3);
			if (cyc >= 320 && cyc < 600)
				m_tready <= 0;
			else case (mode)
				0: m_tready <= 1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 4) != 0);
				default: m_tready <= (cyc % 4 == 0);
			endcase
		end
	end

	// offer one input item at a falling edge and hold it until taken
	task automatic send(input logic [7:0] b, input bit start);
		if (burst_left == 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid = 1;
		s_tdata = b;
		s_tuser = start;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 0;
		sent_items++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++) send(s[i], i == 0);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10) return "0" + v;
		return ($urandom_range(0, 1) ? "a" : "A") + v - 10;
	endfunction

	// wait for the output to drain, then write the byte-order register
	task automatic set_native(input bit v);
		int guard;
		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);
		cfg_we = 1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0;
	endtask

	// one random token: prefix, order letter, delimiter, body pieces, close
	task automatic send_token();
		logic [7:0] q[$];
		logic [7:0] dl;
		logic [31:0] cp;
		int us;
		int n;
		int k;
		us = $urandom_range(0, 3);
		case (us)
			1: begin q.push_back("3"); q.push_back("2"); end
			2: begin q.push_back("1"); q.push_back("6"); end
			3: q.push_back("8");
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0: q.push_back("L");
			1: q.push_back("l");
			2: q.push_back("B");
			3: q.push_back("b");
			default: ;
		endcase
		dl = $urandom_range(0, 3) != 0 ? "\"" : "'";
		q.push_back(dl);
		n = $urandom_range(1, 6);
		for (int p = 0; p < n; p++) begin
			case ($urandom_range(0, 9))
				0, 1: q.push_back(8'($urandom_range(32, 126)));
				2, 3: begin
					// well-formed utf-8 of random length
					case ($urandom_range(0, 2))
						0: cp = $urandom_range(32'h80, 32'h7FF);
						1: begin
							cp = $urandom_range(32'h800, 32'hFFFF);
							if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = 32'hE000;
						end
						default: cp = $urandom_range(32'h10000, 32'h10FFFF);
					endcase
					if (cp < 32'h800) begin
						q.push_back(8'hC0 | cp[10:6]);
						q.push_back(8'h80 | cp[5:0]);
					end else if (cp < 32'h10000) begin
						q.push_back(8'hE0 | cp[15:12]);
						q.push_back(8'h80 | cp[11:6]);
						q.push_back(8'h80 | cp[5:0]);
					end else begin
						q.push_back(8'hF0 | cp[20:18]);
						q.push_back(8'h80 | cp[17:12]);
						q.push_back(8'h80 | cp[11:6]);
						q.push_back(8'h80 | cp[5:0]);
					end
				end
				4: begin
					string esc = "abefntrvz\\'\"q?";
					q.push_back("\\");
					q.push_back(esc[$urandom_range(0, esc.len() - 1)]);
				end
				5, 6: begin
					// hex escape, mostly in range
					k = $urandom_range(0, 2);
					q.push_back("\\");
					q.push_back(k == 0 ? "x" : k == 1 ? "u" : "U");
					cp = (k == 2 && $urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h10FFFF);
					k = (k == 0) ? 2 : (k == 1) ? 4 : 8;
					for (int i = k - 1; i >= 0; i--) q.push_back(hex_char(cp[4*i +: 4]));
					if ($urandom_range(0, 9) == 0) q[q.size() - 1] = "g";
				end
				7: begin
					// octal escape, the first digit counted
					k = (us == 1) ? 11 : (us == 2) ? 6 : 3;
					q.push_back("\\");
					for (int i = 0; i < k; i++)
						q.push_back((i < k - 7 && $urandom_range(0, 3) != 0) ? "0"
							: 8'("0" + $urandom_range(0, 7)));
					if ($urandom_range(0, 9) == 0) q[q.size() - 1] = "9";
				end
				default: q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		// most tokens close; some are cut short by the next token
		if ($urandom_range(0, 7) != 0) q.push_back(dl);
		if ($urandom_range(0, 9) == 0) q.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < q.size(); i++) send(q[i], i == 0);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed tokens: widths, order letters, escapes and error cases
		send_str("32L'\\U0010FFFF\\x00'");
		send_str("16B\"\\u00e9\"");
		send_str("3x\\3773");
		send_str("\"\\q\xC0\xF4\x90\x80\x80\"");
		send_str("8b'\xE0\x80''");
		send(8'hFF, 1);

		set_native(0);
		send_str("16'\\U0001F600'");
		send_str("32\"\\x1g\\12\"");
		set_native(1);
		while (sent_items < 120) send_token();
		set_native(0);
		while (sent_items < 195) send_token();
		set_native(1'($urandom_range(0, 1)));
		while (sent_items < 255) send_token();

		begin
			int guard;
			guard = 0;
			while (pending != 0 && guard < 50000) begin
				@(posedge clk);
				guard++;
			end
		end
		repeat (30) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("** string_literal_escape_transcoder: PASSED **");
		else
			$display("** string_literal_escape_transcoder: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** string_literal_escape_transcoder: FAILED **");
		$finish;
	end

endmodule
